FILE: design/rc_link_frame_parser_defines.svh
// Assertion macros shared by the RTL of the RC-link frame parser.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RC_LINK_FRAME_PARSER_DEFINES_SVH
`define RC_LINK_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define RCLFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RCLFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/rclfp_pkg.sv
// Shared types and constants of the RC-link frame parser.
// No dependencies; used by rclfp_crc8, rclfp_pulse_div and the top level.
`timescale 1ns / 1ps
package rclfp_pkg;

  localparam logic [7:0]  RC_LENGTH  = 8'd24;
  localparam logic [7:0]  RC_TYPE    = 8'h16;
  localparam logic [7:0]  CRC_POLY   = 8'hD5;
  localparam int          LEN_AT     = 1;
  localparam int          TYPE_AT    = 2;
  localparam int          PAYLOAD_AT = 3;
  localparam int          CRC_AT     = 25;
  localparam int          CHAN_BITS  = 11;
  // (2048*v + 2888047) / 3278 is (1024*v + 1443204) / 1639 rounded half up
  localparam logic [22:0] PULSE_BIAS = 23'd2888047;
  localparam logic [12:0] PULSE_DIV  = 13'd3278;

  typedef struct packed {
    logic clr;
    logic en;
    logic din;
  } crc_ctl_t;

endpackage

FILE: design/rclfp_store.sv
// Frame byte memory: one write port, one registered read port.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
module rclfp_store #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(BUFFER_BYTES)-1:0] wr_addr,
  input  logic [7:0]                      wr_data,
  input  logic [$clog2(BUFFER_BYTES)-1:0] rd_addr,
  output logic [7:0]                      rd_data
);

  logic [7:0] mem_r [BUFFER_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/rclfp_crc8.sv
// Bit-serial CRC-8 (poly 0xD5, init 0), MSB first; one bit per enabled cycle.
// Depends on rclfp_pkg for the control struct and polynomial.
`timescale 1ns / 1ps
module rclfp_crc8 (
  input  logic               clk,
  input  logic               rst_n,
  input  rclfp_pkg::crc_ctl_t ctl,
  output logic [7:0]         crc
);
  import rclfp_pkg::*;

  logic [7:0] crc_r, crc_nxt;
  logic       fb;

  always_comb begin
    fb      = crc_r[7] ^ ctl.din;
    crc_nxt = crc_r;
    if (ctl.clr) begin
      crc_nxt = 8'd0;
    end else if (ctl.en) begin
      crc_nxt = {crc_r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 8'd0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

FILE: design/rclfp_pulse_div.sv
// Serial restoring divider turning an 11-bit channel into microseconds.
// Depends on rclfp_pkg for the bias and divisor; one quotient bit per cycle.
`timescale 1ns / 1ps
module rclfp_pulse_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [10:0] chan,
  output logic        done,
  output logic [11:0] pulse
);
  import rclfp_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [11:0] rem_r;
  logic [11:0] num_r;
  logic [11:0] q_r;
  logic [22:0] num_full;
  logic [12:0] trial;
  logic        ge;

  assign num_full = {chan, 12'd0} / 23'd2 + PULSE_BIAS;
  assign trial    = {rem_r, num_r[11]};
  assign ge       = trial >= PULSE_DIV;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd11) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num_full[22:12]};
      num_r <= num_full[11:0];
      q_r   <= 12'd0;
    end else if (busy_r) begin
      rem_r <= ge ? 12'(trial - PULSE_DIV) : trial[11:0];
      num_r <= {num_r[10:0], 1'b0};
      q_r   <= {q_r[10:0], ge};
    end
  end

  assign done  = done_r;
  assign pulse = q_r;

endmodule

FILE: design/rc_link_frame_parser.sv
// Top level of the RC-link frame parser: sync tracking and frame sequencer.
// Depends on rclfp_pkg, rclfp_store, rclfp_crc8, rclfp_pulse_div and the defines header.
//
// Usage: one received serial byte is a transaction on the input channel
// (in_valid / in_stall / in_rx_byte). While unsynced the parser watches for a
// length byte 24 followed by type 0x16 and aligns the frame on it. Once a
// complete 26-byte RC-channels frame with a good CRC-8 is in, the block emits
// one result transaction per channel on the output channel (out_valid /
// out_stall), in channel order, the last one flagged by out_last_channel.
// A channel_limit of zero gives a single result with out_value_valid low.
// A byte that does not complete a frame leaves in_stall low. A byte that
// completes a good frame holds in_stall high for the CRC sweep (the
// bit-serial CRC, fed through the one memory read port) and then for each
// emitted channel (11-bit serial unpack and the 12-step divider).
// Results sit in an output register: a stalled receiver holds the current
// result and the sequencer waits. Reset (rst_n, synchronous) empties the
// buffer, drops sync and sets channel_limit to 16; buffer contents stay.
`timescale 1ns / 1ps
`include "rc_link_frame_parser_defines.svh"
module rc_link_frame_parser #(
  parameter int BUFFER_BYTES = 64,
  parameter int CHANNELS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_channel_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_channel_index,
  output logic [11:0] out_channel_value,
  output logic [4:0]  out_channel_count,
  output logic        out_last_channel,
  output logic        out_value_valid
);
  import rclfp_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CFETCH = 9'b000000010,
    S_CLOAD  = 9'b000000100,
    S_CBIT   = 9'b000001000,
    S_DFETCH = 9'b000010000,
    S_DLOAD  = 9'b000100000,
    S_DBIT   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic        sync_r, sync_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [4:0]  limit_r;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  chb_r, chb_nxt;
  logic [10:0] acc_r, acc_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [3:0]  o_idx_r, o_idx_nxt;
  logic [11:0] o_val_r, o_val_nxt;
  logic [4:0]  o_cnt_r, o_cnt_nxt;
  logic        o_last_r, o_last_nxt;
  logic        o_vv_r, o_vv_nxt;

  logic        accept;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]  rd_data;
  logic [7:0]  crc;
  crc_ctl_t    crc_ctl;
  logic        div_start;
  logic [10:0] div_chan;
  logic        div_done;
  logic [11:0] div_q;
  logic [FW:0] grown;
  logic [8:0]  flen;
  logic        proc_go;
  logic [4:0]  n_chan;
  logic        k_last;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign n_chan    = (limit_r > 5'(CHANNELS)) ? 5'(CHANNELS) : limit_r;
  assign k_last    = ({1'b0, k_r} + 5'd1) == n_chan;
  assign grown     = {1'b0, fill_r} + {{FW{1'b0}}, 1'b1};
  assign flen      = {1'b0, len_r} + 9'd2;

  // Byte intake: sync hunt while unsynced, frame bookkeeping once synced.
  always_comb begin
    fill_nxt = fill_r;
    sync_nxt = sync_r;
    prev_nxt = prev_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    wr_en    = 1'b0;
    wr_addr  = fill_r[AW-1:0];
    proc_go  = 1'b0;
    if (accept) begin
      if (fill_r == FW'(BUFFER_BYTES)) begin
        fill_nxt = '0;
        sync_nxt = 1'b0;
      end else if (!sync_r) begin
        prev_nxt = in_rx_byte;
        if (fill_r >= FW'(2) && prev_r == RC_LENGTH && in_rx_byte == RC_TYPE) begin
          // realign: previous two bytes plus this one form the frame head
          sync_nxt = 1'b1;
          fill_nxt = FW'(3);
          len_nxt  = RC_LENGTH;
          type_nxt = RC_TYPE;
          wr_en    = 1'b1;
          wr_addr  = AW'(TYPE_AT);
        end else if (grown == (FW + 1)'(BUFFER_BYTES)) begin
          fill_nxt = FW'(3);
        end else begin
          fill_nxt = grown[FW-1:0];
        end
      end else begin
        wr_en = 1'b1;
        if (fill_r == FW'(LEN_AT)) begin
          len_nxt = in_rx_byte;
        end
        if (fill_r == FW'(TYPE_AT)) begin
          type_nxt = in_rx_byte;
        end
        fill_nxt = grown[FW-1:0];
        if (grown >= (FW + 1)'(3)) begin
          if (flen > 9'(BUFFER_BYTES) || flen < 9'd4) begin
            fill_nxt = '0;
            sync_nxt = 1'b0;
          end else if (grown == (FW + 1)'(flen)) begin
            fill_nxt = '0;
            proc_go  = (len_r == RC_LENGTH) && (type_r == RC_TYPE);
          end
        end
      end
    end
  end

  // Frame sequencer: CRC sweep, serial channel unpack, conversion, emission.
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    chb_nxt    = chb_r;
    acc_nxt    = acc_r;
    k_nxt      = k_r;
    o_idx_nxt  = o_idx_r;
    o_val_nxt  = o_val_r;
    o_cnt_nxt  = o_cnt_r;
    o_last_nxt = o_last_r;
    o_vv_nxt   = o_vv_r;
    div_start  = 1'b0;
    div_chan   = {sh_r[0], acc_r[10:1]};
    crc_ctl    = '{clr: proc_go, en: 1'b0, din: sh_r[7]};
    case (state_r)
      S_IDLE: begin
        if (proc_go) begin
          addr_nxt  = AW'(TYPE_AT);
          cnt_nxt   = 3'd0;
          state_nxt = S_CFETCH;
        end
      end
      S_CFETCH: state_nxt = S_CLOAD;
      S_CLOAD: begin
        if (addr_r == AW'(CRC_AT)) begin
          if (crc != rd_data) begin
            state_nxt = S_IDLE;
          end else if (n_chan == 5'd0) begin
            o_idx_nxt  = 4'd0;
            o_val_nxt  = 12'd0;
            o_cnt_nxt  = 5'd0;
            o_last_nxt = 1'b1;
            o_vv_nxt   = 1'b0;
            state_nxt  = S_OUT;
          end else begin
            addr_nxt  = AW'(PAYLOAD_AT);
            k_nxt     = 4'd0;
            cnt_nxt   = 3'd0;
            chb_nxt   = 4'd0;
            state_nxt = S_DFETCH;
          end
        end else begin
          sh_nxt    = rd_data;
          state_nxt = S_CBIT;
        end
      end
      S_CBIT: begin
        crc_ctl.en = 1'b1;
        sh_nxt     = {sh_r[6:0], 1'b0};
        cnt_nxt    = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          addr_nxt  = addr_r + AW'(1);
          state_nxt = S_CFETCH;
        end
      end
      S_DFETCH: state_nxt = S_DLOAD;
      S_DLOAD: begin
        sh_nxt    = rd_data;
        state_nxt = S_DBIT;
      end
      S_DBIT: begin
        sh_nxt  = {1'b0, sh_r[7:1]};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          addr_nxt = addr_r + AW'(1);
        end
        if (chb_r == 4'(CHAN_BITS - 1)) begin
          div_start = 1'b1;
          chb_nxt   = 4'd0;
          state_nxt = S_DIV;
        end else begin
          acc_nxt = {sh_r[0], acc_r[10:1]};
          chb_nxt = chb_r + 4'd1;
          if (cnt_r == 3'd7) begin
            state_nxt = S_DFETCH;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          o_idx_nxt  = k_r;
          o_val_nxt  = div_q;
          o_cnt_nxt  = n_chan;
          o_last_nxt = k_last;
          o_vv_nxt   = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (o_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = (cnt_r == 3'd0) ? S_DFETCH : S_DBIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      sync_r  <= 1'b0;
      limit_r <= 5'd16;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      sync_r  <= sync_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_channel_limit;
      end
    end
  end

  // Payload and datapath registers: no reset needed.
  always_ff @(posedge clk) begin
    prev_r   <= prev_nxt;
    len_r    <= len_nxt;
    type_r   <= type_nxt;
    addr_r   <= addr_nxt;
    sh_r     <= sh_nxt;
    cnt_r    <= cnt_nxt;
    chb_r    <= chb_nxt;
    acc_r    <= acc_nxt;
    k_r      <= k_nxt;
    o_idx_r  <= o_idx_nxt;
    o_val_r  <= o_val_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
    o_vv_r   <= o_vv_nxt;
  end

  rclfp_store #(.BUFFER_BYTES(BUFFER_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  rclfp_crc8 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc)
  );

  rclfp_pulse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .chan  (div_chan),
    .done  (div_done),
    .pulse (div_q)
  );

  assign out_channel_index = o_idx_r;
  assign out_channel_value = o_val_r;
  assign out_channel_count = o_cnt_r;
  assign out_last_channel  = o_last_r;
  assign out_value_valid   = o_vv_r;

  `RCLFP_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FW'(BUFFER_BYTES), "fill count beyond buffer")
  `RCLFP_ASSERT_NOW(a_out_empty, out_valid, fill_r == '0 && sync_r, "result while buffer busy")
  `RCLFP_ASSERT_NEXT(a_last_ends, out_valid && out_last_channel && !out_stall, !out_valid, "result after last channel")
  `RCLFP_ASSERT_NOW(a_novalue, out_valid && !out_value_valid, out_last_channel && out_channel_count == 5'd0, "empty result not alone")

endmodule

FILE: bench/rc_link_frame_parser_tb.sv
// Self-checking bench for the RC-link frame parser: byte stream in, channel results out.
// Depends on rc_link_frame_parser and rclfp_pkg; predicts results itself.
`timescale 1ns / 1ps
module rc_link_frame_parser_tb;
  import rclfp_pkg::*;

  localparam int STORE_BYTES = 64;
  localparam int MAX_CHAN    = 16;
  localparam int WATCHDOG    = 200000;

  // Shape of one result transaction.
  typedef struct packed {
    logic [3:0]  idx;
    logic [11:0] value;
    logic [4:0]  count;
    logic        last;
    logic        vvalid;
  } chan_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [4:0]  cfg_channel_limit;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_channel_index;
  logic [11:0] out_channel_value;
  logic [4:0]  out_channel_count;
  logic        out_last_channel;
  logic        out_value_valid;

  rc_link_frame_parser dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_channel_limit(cfg_channel_limit),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel_index(out_channel_index), .out_channel_value(out_channel_value),
    .out_channel_count(out_channel_count), .out_last_channel(out_last_channel),
    .out_value_valid(out_value_valid)
  );

  // Clock: 12 ns period.
  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Predictor state: a private copy of the parser's buffer, sync flag and limit.
  logic [7:0] shadow_store [STORE_BYTES];
  int         shadow_fill;
  bit         shadow_sync;
  logic [4:0] shadow_limit;

  logic [7:0]   byte_queue [$];    // bytes waiting for the driver
  chan_result_t pending_chans [$]; // predicted channel results, oldest first
  int  error_count;
  int  send_idle_pct;              // chance the sender idles, in percent
  int  stall_pct;                  // chance the receiver stalls, in percent
  int  hold_off_cycles;            // long receiver hold-off, counted below
  int  quiet_cycles;
  bit  stim_done;

  function automatic logic [7:0] crc8_d5(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
    return c;
  endfunction

  // Round-half-up map of an 11-bit stick value to microseconds.
  function automatic logic [11:0] stick_to_us(logic [10:0] v);
    longint unsigned num;
    num = 1024 * longint'(v) + 1443204;
    return 12'((2 * num + 1639) / (2 * 1639));
  endfunction

  function automatic logic [10:0] unpack_stick(int k);
    int bitpos, at;
    logic [23:0] w;
    bitpos = 11 * k;
    at = 3 + (bitpos >> 3);
    w = {shadow_store[at + 2], shadow_store[at + 1], shadow_store[at]};
    return 11'(w >> (bitpos & 7));
  endfunction

  function automatic void drop_front(int n);
    for (int i = 0; i + n < shadow_fill; i++) shadow_store[i] = shadow_store[i + n];
    shadow_fill -= n;
  endfunction

  // Advance the predictor by one accepted byte and queue the channels it yields.
  function automatic void predict_byte(logic [7:0] b);
    int flen, n;
    logic [7:0] crc;
    chan_result_t r;
    if (shadow_fill >= STORE_BYTES) begin
      shadow_fill = 0; shadow_sync = 0;
      return;
    end
    shadow_store[shadow_fill] = b;
    shadow_fill++;
    if (!shadow_sync) begin
      for (int i = 1; i + 1 < shadow_fill; i++) begin
        if (shadow_store[i] == RC_LENGTH && shadow_store[i + 1] == RC_TYPE) begin
          shadow_sync = 1;
          if (i > 1) drop_front(i - 1);
          break;
        end
      end
    end
    if (!shadow_sync) begin
      if (shadow_fill >= STORE_BYTES) begin
        for (int i = 0; i < 3; i++) shadow_store[i] = shadow_store[STORE_BYTES - 3 + i];
        shadow_fill = 3;
      end
      return;
    end
    if (shadow_fill < 3) return;
    flen = int'(shadow_store[1]) + 2;
    if (flen > STORE_BYTES || flen < 4) begin
      shadow_fill = 0; shadow_sync = 0;
      return;
    end
    if (shadow_fill < flen) return;
    if (shadow_store[2] == RC_TYPE && shadow_store[1] == RC_LENGTH) begin
      crc = crc8_d5(8'h00, shadow_store[2]);
      for (int i = 0; i < 22; i++) crc = crc8_d5(crc, shadow_store[3 + i]);
      if (crc == shadow_store[25]) begin
        n = (shadow_limit < MAX_CHAN) ? shadow_limit : MAX_CHAN;
        if (n == 0) begin
          r = '{idx: 4'd0, value: 12'd0, count: 5'd0, last: 1'b1, vvalid: 1'b0};
          pending_chans.push_back(r);
        end else begin
          for (int k = 0; k < n; k++) begin
            r.idx = 4'(k);
            r.value = stick_to_us(unpack_stick(k));
            r.count = 5'(n);
            r.last = (k + 1 == n);
            r.vvalid = 1'b1;
            pending_chans.push_back(r);
          end
        end
      end
    end
    if (shadow_fill > flen) drop_front(flen);
    else shadow_fill = 0;
  endfunction

  // Queue one frame: 22 payload bytes, optional CRC damage.
  task automatic queue_frame(input logic [7:0] payload [22], input bit bad_crc);
    logic [7:0] crc;
    crc = crc8_d5(8'h00, RC_TYPE);
    for (int i = 0; i < 22; i++) crc = crc8_d5(crc, payload[i]);
    byte_queue.push_back(8'hC8);
    byte_queue.push_back(RC_LENGTH);
    byte_queue.push_back(RC_TYPE);
    foreach (payload[i]) byte_queue.push_back(payload[i]);
    byte_queue.push_back(bad_crc ? crc ^ 8'(1 << $urandom_range(7, 0)) : crc);
  endtask

  task automatic queue_random_frame(input bit bad_crc);
    logic [7:0] p [22];
    foreach (p[i]) p[i] = 8'($urandom);
    queue_frame(p, bad_crc);
  endtask

  task automatic queue_fill_frame(input logic [7:0] fill);
    logic [7:0] p [22];
    foreach (p[i]) p[i] = fill;
    queue_frame(p, 1'b0);
  endtask

  // Wait until all bytes went in and every predicted result came out, then settle.
  task automatic drain();
    while (byte_queue.size() != 0 || pending_chans.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  // Write channel_limit while the parser is idle.
  task automatic write_limit(input logic [4:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_channel_limit <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_limit = v;
  endtask

  // Driver: present the head of byte_queue; advance on a handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(in_rx_byte);
        void'(byte_queue.pop_front());
      end
      // Hold a payload that was not taken; otherwise decide on the next one.
      if (in_valid && in_stall) begin
        // keep offering
      end else if (byte_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= byte_queue[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: a long hold-off when requested, otherwise random.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    chan_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chans.size() == 0) begin
        $error("unexpected result: index %0d value %0d", out_channel_index, out_channel_value);
        error_count++;
      end else begin
        want = pending_chans.pop_front();
        if (out_channel_index !== want.idx) begin
          $error("channel_index expected %0d got %0d", want.idx, out_channel_index);
          error_count++;
        end
        if (out_channel_value !== want.value) begin
          $error("channel_value expected %0d got %0d", want.value, out_channel_value);
          error_count++;
        end
        if (out_channel_count !== want.count) begin
          $error("channel_count expected %0d got %0d", want.count, out_channel_count);
          error_count++;
        end
        if (out_last_channel !== want.last) begin
          $error("last_channel expected %0d got %0d", want.last, out_last_channel);
          error_count++;
        end
        if (out_value_valid !== want.vvalid) begin
          $error("value_valid expected %0d got %0d", want.vvalid, out_value_valid);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || stim_done)
      quiet_cycles <= 0;
    else if (byte_queue.size() != 0 || pending_chans.size() != 0)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Random phase: mostly well-formed frames, some broken ones and noise.
  task automatic random_phase(input int n_items);
    int start, sel;
    start = byte_queue.size();
    while (byte_queue.size() - start < n_items) begin
      sel = $urandom_range(99, 0);
      if (sel < 60) queue_random_frame(1'b0);
      else if (sel < 70) queue_random_frame(1'b1);
      else if (sel < 80) begin
        // truncated frame: sync pair then a few bytes
        byte_queue.push_back(8'($urandom));
        byte_queue.push_back(RC_LENGTH);
        byte_queue.push_back(RC_TYPE);
        repeat ($urandom_range(10, 0)) byte_queue.push_back(8'($urandom));
      end else if (sel < 85) begin
        // other frame type with a valid length
        byte_queue.push_back(8'hC8);
        byte_queue.push_back(8'd4);
        byte_queue.push_back(8'h14);
        repeat (4) byte_queue.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(8, 1)) byte_queue.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_channel_limit = 5'd16;
    in_rx_byte = 8'h00;
    in_valid = 1'b0;
    out_stall = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    stim_done = 0;
    shadow_fill = 0;
    shadow_sync = 0;
    shadow_limit = 5'd16;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme channel values, the all-ones frame under a saturating limit, then a zero limit.
    queue_fill_frame(8'h00);
    write_limit(5'd31);
    queue_fill_frame(8'hFF);
    write_limit(5'd0);
    queue_random_frame(1'b0);
    write_limit(5'd16);
    // Bogus lengths while synced: one below the minimum, one beyond the store.
    byte_queue.push_back(8'hC8);
    byte_queue.push_back(8'd1);
    byte_queue.push_back(8'h00);
    queue_random_frame(1'b0);
    byte_queue.push_back(8'hC8);
    byte_queue.push_back(8'd200);
    byte_queue.push_back(8'h16);
    // Full store while unsynced: bytes that never form a sync pair.
    repeat (66) byte_queue.push_back(8'h00);
    queue_random_frame(1'b0);

    // No idling.
    send_idle_pct = 0; stall_pct = 0;
    random_phase(20);
    // Sender mostly idle.
    write_limit(5'($urandom_range(16, 1)));
    send_idle_pct = 85; stall_pct = 0;
    random_phase(20);
    // Receiver mostly stalling, with one long hold-off while bytes keep coming.
    write_limit(5'd16);
    send_idle_pct = 0; stall_pct = 85;
    hold_off_cycles = 3000;
    random_phase(20);
    // Both.
    write_limit(5'($urandom_range(31, 0)));
    send_idle_pct = 37; stall_pct = 37;
    random_phase(20);
    drain();
    stim_done = 1;

    if (error_count == 0 && pending_chans.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
